/* rtl/box_sphere_classifier_macros.svh */
// ----------------------------------------------------------------------------
// box sphere classifier assertion macros
// concurrent assertion shorthands used by box_sphere_classifier
// ----------------------------------------------------------------------------
`ifndef BOX_SPHERE_CLASSIFIER_MACROS_SVH
`define BOX_SPHERE_CLASSIFIER_MACROS_SVH

// same-cycle implication, disabled during reset
`define BSC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// next-cycle implication, disabled during reset
`define BSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* rtl/bsc_pkg.sv */
// ----------------------------------------------------------------------------
// bsc_pkg
// shared constants and register codes of the box sphere classifier
// ----------------------------------------------------------------------------
`default_nettype none

package bsc_pkg;

   localparam int COORD_BITS_DEFAULT = 16;
   localparam int CSR_INDEX_BITS     = 3;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam csr_index_type CSR_CENTER_X = csr_index_type'(0);
   localparam csr_index_type CSR_CENTER_Y = csr_index_type'(1);
   localparam csr_index_type CSR_CENTER_Z = csr_index_type'(2);
   localparam csr_index_type CSR_RADIUS   = csr_index_type'(3);

endpackage

`default_nettype wire

/* rtl/bsc_if.sv */
// ----------------------------------------------------------------------------
// bsc channel interfaces
// request, response and register write channels with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface bsc_req_if #(
   parameter int COORD_BITS = bsc_pkg::COORD_BITS_DEFAULT
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] min_x;
   logic signed [COORD_BITS-1:0] min_y;
   logic signed [COORD_BITS-1:0] min_z;
   logic signed [COORD_BITS-1:0] max_x;
   logic signed [COORD_BITS-1:0] max_y;
   logic signed [COORD_BITS-1:0] max_z;

   modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z, input ready);
   modport sink   (input valid, min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

interface bsc_rsp_if;
   logic valid;
   logic ready;
   logic fully_inside;
   logic surely_outside;

   modport source (output valid, fully_inside, surely_outside, input ready);
   modport sink   (input valid, fully_inside, surely_outside, output ready);
endinterface

interface bsc_csr_if #(
   parameter int COORD_BITS = bsc_pkg::COORD_BITS_DEFAULT
);
   logic                     valid;
   logic                     ready;
   bsc_pkg::csr_index_type   index;
   logic [COORD_BITS-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/box_sphere_classifier.sv */
// ----------------------------------------------------------------------------
// box_sphere_classifier
// classifies an axis-aligned box as fully inside or surely outside a sphere
// ----------------------------------------------------------------------------
// One box request is taken every cycle while req_if.ready is high, and its
// flags appear in request order. The four register stages are:
// input capture, per-axis distances to the centre plus the grown-box test,
// the six per-axis squares and the squared radius, then the eight corner sums
// compared against the squared radius. The squaring stage sets the clock,
// each distance multiplier being COORD_BITS by COORD_BITS. A stalled response
// holds the pipeline back stage by stage, so bubbles are squeezed out before
// the input stops taking requests. Centre and radius are written through the
// register port (index 0..2 centre x, y, z, index 3 radius, other indexes
// ignored) and must only change while no request is in flight.
`default_nettype none
`include "box_sphere_classifier_macros.svh"

module box_sphere_classifier #(
   parameter int COORD_BITS = bsc_pkg::COORD_BITS_DEFAULT
) (
   input  wire        clock,
   input  wire        reset,
   bsc_req_if.sink    req_if,
   bsc_rsp_if.source  rsp_if,
   bsc_csr_if.sink    csr_if
);

   localparam int W  = COORD_BITS;
   localparam int SQ = 2 * W;
   localparam int SUM = SQ + 2;
   localparam int R2 = 2 * (W - 1);

   // configuration registers
   logic signed [W-1:0] center_ff [3];
   logic        [W-2:0] radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff[0] <= '0;
         center_ff[1] <= '0;
         center_ff[2] <= '0;
         radius_ff    <= '0;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            bsc_pkg::CSR_CENTER_X: center_ff[0] <= csr_if.data;
            bsc_pkg::CSR_CENTER_Y: center_ff[1] <= csr_if.data;
            bsc_pkg::CSR_CENTER_Z: center_ff[2] <= csr_if.data;
            bsc_pkg::CSR_RADIUS:   radius_ff    <= csr_if.data[W-2:0];
            default: ;
         endcase
      end
   end

   assign csr_if.ready = 1'b1;

   // stage enables, each stage moves when empty or when the next one moves
   logic in_en, dif_en, sq_en, out_en;
   logic in_valid_ff,  in_valid_in;
   logic dif_valid_ff, dif_valid_in;
   logic sq_valid_ff,  sq_valid_in;
   logic out_valid_ff, out_valid_in;

   assign out_en = !out_valid_ff || rsp_if.ready;
   assign sq_en  = !sq_valid_ff  || out_en;
   assign dif_en = !dif_valid_ff || sq_en;
   assign in_en  = !in_valid_ff  || dif_en;

   assign in_valid_in  = in_en  ? req_if.valid : 1'b1;
   assign dif_valid_in = dif_en ? in_valid_ff  : 1'b1;
   assign sq_valid_in  = sq_en  ? dif_valid_ff : 1'b1;
   assign out_valid_in = out_en ? sq_valid_ff  : 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         dif_valid_ff <= 1'b0;
         sq_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         dif_valid_ff <= dif_valid_in;
         sq_valid_ff  <= sq_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_if.ready = in_en;

   // input capture
   logic signed [W-1:0] lo_ff [3];
   logic signed [W-1:0] hi_ff [3];

   always_ff @(posedge clock) begin
      if (in_en) begin
         lo_ff[0] <= req_if.min_x;
         lo_ff[1] <= req_if.min_y;
         lo_ff[2] <= req_if.min_z;
         hi_ff[0] <= req_if.max_x;
         hi_ff[1] <= req_if.max_y;
         hi_ff[2] <= req_if.max_z;
      end
   end

   // distance magnitudes and grown-box test
   logic signed [W:0]   lo_diff [3];
   logic signed [W:0]   hi_diff [3];
   logic        [W-1:0] lo_mag_in [3];
   logic        [W-1:0] hi_mag_in [3];
   logic        [W-1:0] lo_mag_ff [3];
   logic        [W-1:0] hi_mag_ff [3];
   logic signed [W:0]   radius_ext;
   logic [2:0]          below_lo, above_hi;
   logic                beyond_in, beyond_dif_ff, beyond_sq_ff;

   assign radius_ext = $signed({2'b00, radius_ff});

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         lo_diff[a]   = {lo_ff[a][W-1], lo_ff[a]} - {center_ff[a][W-1], center_ff[a]};
         hi_diff[a]   = {hi_ff[a][W-1], hi_ff[a]} - {center_ff[a][W-1], center_ff[a]};
         lo_mag_in[a] = lo_diff[a][W] ? W'(-lo_diff[a]) : lo_diff[a][W-1:0];
         hi_mag_in[a] = hi_diff[a][W] ? W'(-hi_diff[a]) : hi_diff[a][W-1:0];
         below_lo[a]  = $signed({center_ff[a][W-1], center_ff[a]})
                        < ($signed({lo_ff[a][W-1], lo_ff[a]}) - radius_ext);
         above_hi[a]  = $signed({center_ff[a][W-1], center_ff[a]})
                        > ($signed({hi_ff[a][W-1], hi_ff[a]}) + radius_ext);
      end
   end

   assign beyond_in = |below_lo || |above_hi;

   always_ff @(posedge clock) begin
      if (dif_en) begin
         lo_mag_ff     <= lo_mag_in;
         hi_mag_ff     <= hi_mag_in;
         beyond_dif_ff <= beyond_in;
      end
   end

   // squares
   logic [SQ-1:0] lo_sq_ff [3];
   logic [SQ-1:0] hi_sq_ff [3];
   logic [R2-1:0] r2_ff;

   always_ff @(posedge clock) begin
      if (sq_en) begin
         for (int a = 0; a < 3; a++) begin
            lo_sq_ff[a] <= SQ'(lo_mag_ff[a] * lo_mag_ff[a]);
            hi_sq_ff[a] <= SQ'(hi_mag_ff[a] * hi_mag_ff[a]);
         end
         r2_ff        <= R2'(radius_ff * radius_ff);
         beyond_sq_ff <= beyond_dif_ff;
      end
   end

   // corner sums, bit 0/1/2 of the corner number picks max on x/y/z
   logic [SUM-1:0] corner_sum;
   logic [SUM-1:0] r2_ext;
   logic           all_in, all_out;
   logic           fully_inside_in, surely_outside_in;
   logic           fully_inside_ff, surely_outside_ff;

   assign r2_ext = {4'b0000, r2_ff};

   always_comb begin
      all_in     = 1'b1;
      all_out    = 1'b1;
      corner_sum = '0;
      for (int k = 0; k < 8; k++) begin
         corner_sum = {2'b00, (k[0] ? hi_sq_ff[0] : lo_sq_ff[0])}
                    + {2'b00, (k[1] ? hi_sq_ff[1] : lo_sq_ff[1])}
                    + {2'b00, (k[2] ? hi_sq_ff[2] : lo_sq_ff[2])};
         if (!(corner_sum < r2_ext)) begin
            all_in = 1'b0;
         end
         if (!(corner_sum > r2_ext)) begin
            all_out = 1'b0;
         end
      end
   end

   assign fully_inside_in   = all_in;
   assign surely_outside_in = all_out && beyond_sq_ff;

   always_ff @(posedge clock) begin
      if (out_en) begin
         fully_inside_ff   <= fully_inside_in;
         surely_outside_ff <= surely_outside_in;
      end
   end

   assign rsp_if.valid          = out_valid_ff;
   assign rsp_if.fully_inside   = fully_inside_ff;
   assign rsp_if.surely_outside = surely_outside_ff;

   // a box cannot be both inside and outside
   `BSC_ASSERT_IMPLIES(flags_exclusive, clock, reset,
      out_valid_ff, !(fully_inside_ff && surely_outside_ff))

   // a full pipeline behind a stalled response must refuse requests
   `BSC_ASSERT_IMPLIES(full_stall_blocks, clock, reset,
      out_valid_ff && !rsp_if.ready && in_valid_ff && dif_valid_ff && sq_valid_ff,
      !req_if.ready)

   // a finished sum always reaches the response register
   `BSC_ASSERT_NEXT(squares_reach_output, clock, reset,
      sq_valid_ff && !out_valid_ff, out_valid_ff)

endmodule

`default_nettype wire
